@@ rtl/tgarle_pkg.sv @@
// ----------------------------------------------------------------------------
// tgarle_pkg
// Shared types, constants and helpers of the TGA run-length pixel decoder.
// ----------------------------------------------------------------------------
package tgarle_pkg;

    localparam int BYTE_W     = 8;
    localparam int BPP_W      = 3;
    localparam int PIXCNT_W   = 24;
    localparam int PIXEL_W    = 32;
    localparam int REPEAT_W   = 8;
    localparam int BIP_W      = 2;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = PIXCNT_W;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 40;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_BYTES_PER_PIXEL = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_PIXEL_COUNT     = 1'b1;

    localparam logic [BPP_W-1:0]    BPP_RESET    = 3'd3;
    localparam logic [PIXCNT_W-1:0] PIXCNT_RESET = 24'd1;

    // packet header decode
    localparam logic [BYTE_W-1:0] RUN_FLAG_MIN = 8'd128;
    localparam logic [BYTE_W-1:0] RUN_BIAS     = 8'd127;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic              sof;
    } t_in_beat;

    typedef struct packed {
        logic [PIXEL_W-1:0]  pixel_value;
        logic [REPEAT_W-1:0] repeat_res;
        logic                last_of_image;
        logic                overrun;
    } t_result;

    // effective pixel size: 0 acts as 1, 5..7 act as 4
    function automatic logic [BPP_W-1:0] pixel_size(input logic [BPP_W-1:0] bpp);
        logic [BPP_W-1:0] s;
        if (bpp == 3'd0) begin
            s = 3'd1;
        end else if (bpp > 3'd4) begin
            s = 3'd4;
        end else begin
            s = bpp;
        end
        return s;
    endfunction

endpackage

@@ rtl/tga_rle_pixel_decoder_top.sv @@
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_top
// TGA run-length pixel stream decoder, one coded byte per beat.
//
//  channel   dir  tdata                              tuser            tlast
//  s_axis    in   [7:0] stream_byte                  start_of_image   -
//  m_axis    out  [31:0] pixel_value,[39:32] repeat  overrun          last_of_image
//  cfg       in   0 bytes_per_pixel, 1 pixel_count   -                -
//
//  One byte per cycle sustained while the result side does not stall; a beat
//  passes through the input register, then is decoded into the result register.
//  Reset is synchronous; it clears the stream state and sets the registers
//  to 3 bytes per pixel and a count of 1.
//  A stalled result holds the decode stage; the input register still takes one beat.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tgarle_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [tgarle_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [tgarle_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // [7:0] stream_byte
    input  logic                                s_axis_tuser,  // [0] start_of_image
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [tgarle_pkg::M_TDATA_W-1:0]    m_axis_tdata,  // [31:0] pixel, [39:32] repeat
    output logic                                m_axis_tuser,  // [0] overrun
    output logic                                m_axis_tlast
);

    tgarle_pkg::t_in_beat beat;
    tgarle_pkg::t_result  res;
    logic                 take;

    tgarle_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata[tgarle_pkg::BYTE_W-1:0]),
        .i_sof   (s_axis_tuser),
        .i_take  (take),
        .o_beat  (beat)
    );

    tgarle_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_beat      (beat),
        .o_take      (take),
        .i_res_ready (m_axis_tready),
        .o_res_valid (m_axis_tvalid),
        .o_res       (res)
    );

    assign m_axis_tdata = {res.repeat_res, res.pixel_value};
    assign m_axis_tuser = res.overrun;
    assign m_axis_tlast = res.last_of_image;

endmodule

@@ rtl/tgarle_in_stage.sv @@
// ----------------------------------------------------------------------------
// tgarle_in_stage
// Input register: holds one stream beat until the decode stage takes it.
// ----------------------------------------------------------------------------
module tgarle_in_stage (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [tgarle_pkg::BYTE_W-1:0]     i_data,
    input  logic                              i_sof,
    input  logic                              i_take,
    output tgarle_pkg::t_in_beat              o_beat
);

    logic                          r_valid;
    logic [tgarle_pkg::BYTE_W-1:0] r_data;
    logic                          r_sof;
    logic                          n_valid;
    logic                          load;

    assign o_ready = !r_valid || i_take;
    assign load    = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= i_data;
            r_sof  <= i_sof;
        end
    end

    assign o_beat.valid = r_valid;
    assign o_beat.data  = r_data;
    assign o_beat.sof   = r_sof;

endmodule

@@ rtl/tgarle_core.sv @@
// ----------------------------------------------------------------------------
// tgarle_core
// Packet decode, pixel gather, image count and result register.
// ----------------------------------------------------------------------------
module tgarle_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tgarle_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [tgarle_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  tgarle_pkg::t_in_beat                i_beat,
    output logic                                o_take,
    input  logic                                i_res_ready,
    output logic                                o_res_valid,
    output tgarle_pkg::t_result                 o_res
);

    localparam int PCW = tgarle_pkg::PIXCNT_W;
    localparam int RW  = tgarle_pkg::REPEAT_W;

    logic [tgarle_pkg::BPP_W-1:0]   r_bpp;
    logic [PCW-1:0]                 r_pixcnt;

    logic                           r_expect, n_expect;
    logic                           r_run, n_run;
    logic [RW-1:0]                  r_left, n_left;
    logic [tgarle_pkg::BIP_W-1:0]   r_bip, n_bip;
    logic [tgarle_pkg::PIXEL_W-1:0] r_gather, n_gather;
    logic [PCW-1:0]                 r_done, n_done;
    logic                           r_halt, n_halt;

    logic                           r_res_valid, n_res_valid;
    tgarle_pkg::t_result            r_res, n_res;

    logic                           c_expect, c_run, c_halt;
    logic [RW-1:0]                  c_left;
    logic [tgarle_pkg::BIP_W-1:0]   c_bip;
    logic [tgarle_pkg::PIXEL_W-1:0] c_gather;
    logic [PCW-1:0]                 c_done;

    logic [tgarle_pkg::PIXEL_W-1:0] gath;
    logic [tgarle_pkg::BIP_W-1:0]   bip_inc;
    logic [tgarle_pkg::BPP_W-1:0]   psize;
    logic                           complete;
    logic [RW-1:0]                  rep;
    logic [RW-1:0]                  left_after;
    logic                           rem_zero;
    logic [PCW-1:0]                 remaining;
    logic                           rep_gt;
    logic                           rep_ge;
    logic [RW-1:0]                  clipped;
    logic                           emit;

    assign o_take = i_beat.valid && (!r_res_valid || i_res_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp    <= tgarle_pkg::BPP_RESET;
            r_pixcnt <= tgarle_pkg::PIXCNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                tgarle_pkg::REG_BYTES_PER_PIXEL: r_bpp    <= i_cfg_wdata[tgarle_pkg::BPP_W-1:0];
                tgarle_pkg::REG_PIXEL_COUNT:     r_pixcnt <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // start of image clears the stream state ahead of this byte
    always_comb begin
        c_expect = i_beat.sof ? 1'b1 : r_expect;
        c_run    = i_beat.sof ? 1'b0 : r_run;
        c_left   = i_beat.sof ? '0   : r_left;
        c_bip    = i_beat.sof ? '0   : r_bip;
        c_gather = i_beat.sof ? '0   : r_gather;
        c_done   = i_beat.sof ? '0   : r_done;
        c_halt   = i_beat.sof ? 1'b0 : r_halt;
    end

    always_comb begin
        gath = c_gather;
        case (c_bip)
            2'd0: gath[7:0]   = c_gather[7:0]   | i_beat.data;
            2'd1: gath[15:8]  = c_gather[15:8]  | i_beat.data;
            2'd2: gath[23:16] = c_gather[23:16] | i_beat.data;
            2'd3: gath[31:24] = c_gather[31:24] | i_beat.data;
            default: gath = c_gather;
        endcase
    end

    assign bip_inc  = c_bip + 2'd1;
    assign psize    = tgarle_pkg::pixel_size(r_bpp);
    assign complete = (bip_inc == 2'd0) || ({1'b0, bip_inc} >= psize);

    assign rep        = c_run ? c_left : 8'd1;
    assign left_after = c_run ? 8'd0 : c_left - 8'd1;
    assign rem_zero   = !(r_pixcnt > c_done);
    assign remaining  = rem_zero ? '0 : r_pixcnt - c_done;
    assign rep_gt     = {{(PCW-RW){1'b0}}, rep} > remaining;
    assign rep_ge     = {{(PCW-RW){1'b0}}, rep} >= remaining;
    assign clipped    = rep_gt ? remaining[RW-1:0] : rep;

    always_comb begin
        n_expect = c_expect;
        n_run    = c_run;
        n_left   = c_left;
        n_bip    = c_bip;
        n_gather = c_gather;
        n_done   = c_done;
        n_halt   = c_halt;
        emit     = 1'b0;
        n_res    = r_res;
        if (!c_halt) begin
            if (c_expect) begin
                if (i_beat.data < tgarle_pkg::RUN_FLAG_MIN) begin
                    n_run  = 1'b0;
                    n_left = i_beat.data + 8'd1;
                end else begin
                    n_run  = 1'b1;
                    n_left = i_beat.data - tgarle_pkg::RUN_BIAS;
                end
                n_expect = 1'b0;
                n_bip    = '0;
                n_gather = '0;
            end else if (!complete) begin
                n_gather = gath;
                n_bip    = bip_inc;
            end else begin
                emit     = 1'b1;
                n_bip    = '0;
                n_gather = '0;
                n_left   = left_after;
                n_expect = (left_after == 8'd0);
                n_done   = c_done + {{(PCW-RW){1'b0}}, clipped};
                n_halt   = rep_ge;
                n_res.pixel_value   = gath;
                n_res.repeat_res    = clipped;
                n_res.last_of_image = rep_ge;
                n_res.overrun       = rep_gt || (rep_ge && (left_after != 8'd0));
            end
        end
    end

    always_comb begin
        n_res_valid = r_res_valid;
        if (o_take && emit) begin
            n_res_valid = 1'b1;
        end else if (i_res_ready) begin
            n_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect    <= 1'b1;
            r_run       <= 1'b0;
            r_left      <= '0;
            r_bip       <= '0;
            r_gather    <= '0;
            r_done      <= '0;
            r_halt      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_expect <= n_expect;
                r_run    <= n_run;
                r_left   <= n_left;
                r_bip    <= n_bip;
                r_gather <= n_gather;
                r_done   <= n_done;
                r_halt   <= n_halt;
            end
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && emit) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

@@ rtl/tgarle_checker.sv @@
// ----------------------------------------------------------------------------
// tgarle_checker
// Port-level checks on the decoder's result stream.
// ----------------------------------------------------------------------------
module tgarle_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [tgarle_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                m_axis_tuser,
    input  logic                                m_axis_tlast
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    a_overrun_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("overrun without last of image");

    a_zero_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[39:32] == 8'd0) |-> m_axis_tuser)
        else $error("zero repeat without overrun");

    a_repeat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[39:32] <= 8'd128))
        else $error("repeat above packet maximum");

endmodule

bind tga_rle_pixel_decoder_top tgarle_checker u_tgarle_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
